/* src/afu_pkg.sv */
// Package for the activation function unit: fixed-point formats, constants,
// selector codes and the side-band record that travels down the pipeline.
// No dependencies.
`default_nettype none

package afu_pkg;

  // Sample and result format
  localparam int FRAC_BITS = 12;
  localparam int DATA_W    = 16;

  // Internal magnitudes carry 30 fraction bits
  localparam int IBITS  = 30;
  localparam int SH_IN  = IBITS - FRAC_BITS;
  localparam int A_W    = DATA_W + 1 + SH_IN;
  localparam int K_W    = (A_W - 29 > 7) ? A_W - 29 : 7;

  localparam logic [31:0] ONE_Q30 = 32'd1 << IBITS;
  localparam logic [63:0] LN2_Q30 = 64'd744261118;

  // Range reduction: k = floor(a / ln2) by reciprocal multiply, one fix-up
  localparam int          RECIP_SH = 32;
  localparam logic [63:0] RECIP_LN2 = (64'd1 << (SH_IN + RECIP_SH)) / LN2_Q30;

  localparam int EXP_CUTOFF   = 40;
  localparam int TAYLOR_TERMS = 14;

  // Exact floor division of a 30-bit value by a small constant
  localparam int DIV_SH = 34;

  // Activation selector codes
  typedef enum logic [1:0] {
    SEL_SIGMOID = 2'd0,
    SEL_RELU    = 2'd1,
    SEL_TANH    = 2'd2
  } sel_t;

  // Request fields that ride along with the arithmetic
  typedef struct packed {
    logic [1:0]        sel;
    logic              slope;
    logic              neg;
    logic [DATA_W-1:0] raw;
  } side_t;

  // Exponential series state between stages
  typedef struct packed {
    side_t              side;
    logic [29:0]        r;
    logic [K_W-1:0]     k;
    logic               zero;
    logic signed [32:0] sum;
  } exp_ctl_t;

endpackage

`default_nettype wire

/* src/afu_req_if.sv */
// Request channel of the activation function unit: valid/ready plus the
// selector, derivative flag and sample. Depends on afu_pkg.
`default_nettype none

interface afu_req_if import afu_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic                     want_slope;
  logic signed [DATA_W-1:0] sample;

  modport source (output valid, req_type, want_slope, sample, input ready);
  modport sink   (input valid, req_type, want_slope, sample, output ready);
endinterface

`default_nettype wire

/* src/afu_rsp_if.sv */
// Result channel of the activation function unit: valid/ready plus the
// activation value. Depends on afu_pkg.
`default_nettype none

interface afu_rsp_if import afu_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] activation;

  modport source (output valid, activation, input ready);
  modport sink   (input valid, activation, output ready);
endinterface

`default_nettype wire

/* src/activation_function_unit.sv */
// Activation function unit top level: sigmoid, ReLU and tanh with derivatives.
// Depends on afu_pkg, afu_req_if and afu_rsp_if.
`default_nettype none

// Takes one signed Q4.12 word per cycle and returns one saturated Q4.12 word
// per request, in order. The pipeline has 66 register stages: input capture,
// three stages of range reduction for e^-x, two stages per term of a 14-term
// series, one exponent shift stage, a 31-stage restoring divider (one
// quotient bit per stage), a product stage and the rounding stage that feeds
// the output register. All stages advance together whenever the output word
// is free or being taken, so a new request is accepted every cycle unless the
// consumer holds off a waiting result.
module activation_function_unit import afu_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  afu_req_if.sink     req,
  afu_rsp_if.source   rsp
);

  localparam int DV_STEPS = IBITS + 1;

  logic adv;

  // Advance the whole pipe when the output register is free or drained
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  // ---------------- input capture ----------------
  side_t            s1_side;
  logic             s1_vld;
  logic [A_W-1:0]   s1_a;
  logic [DATA_W:0]  s1_m2;
  logic [DATA_W:0]  in_mag;
  logic [DATA_W:0]  in_m2;

  always_comb begin
    in_mag = req.sample[DATA_W-1] ? ((DATA_W+1)'(1) << DATA_W) - {1'b0, req.sample}
                                  : {1'b0, req.sample};
    in_m2  = (req.req_type == SEL_TANH) ? in_mag << 1 : in_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= req.valid;
    end
    if (adv) begin
      s1_side.sel   <= req.req_type;
      s1_side.slope <= req.want_slope;
      s1_side.neg   <= req.sample[DATA_W-1];
      s1_side.raw   <= req.sample;
      s1_m2         <= in_m2;
      s1_a          <= A_W'(in_m2) << SH_IN;
    end
  end

  // ---------------- range reduction: quotient estimate ----------------
  side_t          s2_side;
  logic           s2_vld;
  logic [A_W-1:0] s2_a;
  logic [K_W-1:0] s2_q;
  logic [63:0]    s2_prod;

  assign s2_prod = 64'(s1_m2) * RECIP_LN2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
    if (adv) begin
      s2_side <= s1_side;
      s2_a    <= s1_a;
      s2_q    <= s2_prod[RECIP_SH +: K_W];
    end
  end

  // ---------------- range reduction: remainder ----------------
  side_t          s3_side;
  logic           s3_vld;
  logic [K_W-1:0] s3_q;
  logic [31:0]    s3_r;
  logic [63:0]    s3_diff;

  assign s3_diff = 64'(s2_a) - 64'(s2_q) * LN2_Q30;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (adv) begin
      s3_vld <= s2_vld;
    end
    if (adv) begin
      s3_side <= s2_side;
      s3_q    <= s2_q;
      s3_r    <= s3_diff[31:0];
    end
  end

  // ---------------- series: term and sum per stage ----------------
  exp_ctl_t     tm_ctl  [0:TAYLOR_TERMS];
  logic [30:0]  tm_term [0:TAYLOR_TERMS];
  logic         tm_vld  [0:TAYLOR_TERMS];
  exp_ctl_t     mv_ctl  [1:TAYLOR_TERMS];
  logic [29:0]  mv_v    [1:TAYLOR_TERMS];
  logic         mv_vld  [1:TAYLOR_TERMS];

  logic           fix_ge;
  logic [K_W-1:0] fix_k;

  assign fix_ge = 64'(s3_r) >= LN2_Q30;
  assign fix_k  = fix_ge ? s3_q + K_W'(1) : s3_q;

  // Fix the quotient by one step and seed the series
  always_ff @(posedge clk) begin
    if (rst) begin
      tm_vld[0] <= 1'b0;
    end else if (adv) begin
      tm_vld[0] <= s3_vld;
    end
    if (adv) begin
      tm_ctl[0].side <= s3_side;
      tm_ctl[0].r    <= fix_ge ? 30'(64'(s3_r) - LN2_Q30) : s3_r[29:0];
      tm_ctl[0].k    <= fix_k;
      tm_ctl[0].zero <= fix_k >= K_W'(EXP_CUTOFF);
      tm_ctl[0].sum  <= 33'(ONE_Q30);
      tm_term[0]     <= ONE_Q30[30:0];
    end
  end

  for (genvar n = 1; n <= TAYLOR_TERMS; n++) begin : g_term
    localparam logic [63:0] MN = ((64'd1 << DIV_SH) + 64'(n) - 64'd1) / 64'(n);

    logic [60:0]        a_prod;
    logic [63:0]        b_prod;
    logic [29:0]        b_q;
    logic signed [32:0] b_sum;
    exp_ctl_t           ctl_next;

    assign a_prod = 61'(tm_term[n-1]) * 61'(tm_ctl[n-1].r);
    assign b_prod = 64'(mv_v[n]) * MN;
    assign b_q    = (n == 1) ? mv_v[n] : b_prod[DIV_SH +: 30];
    assign b_sum  = (n % 2 == 1) ? mv_ctl[n].sum - 33'(b_q) : mv_ctl[n].sum + 33'(b_q);

    // Carry the control record with the updated sum
    always_comb begin
      ctl_next     = mv_ctl[n];
      ctl_next.sum = b_sum;
    end

    // Multiply previous term by r
    always_ff @(posedge clk) begin
      if (rst) begin
        mv_vld[n] <= 1'b0;
      end else if (adv) begin
        mv_vld[n] <= tm_vld[n-1];
      end
      if (adv) begin
        mv_ctl[n] <= tm_ctl[n-1];
        mv_v[n]   <= a_prod[59:30];
      end
    end

    // Divide by the term index and accumulate with alternating sign
    always_ff @(posedge clk) begin
      if (rst) begin
        tm_vld[n] <= 1'b0;
      end else if (adv) begin
        tm_vld[n] <= mv_vld[n];
      end
      if (adv) begin
        tm_ctl[n]     <= ctl_next;
        tm_term[n]    <= 31'(b_q);
      end
    end
  end

  // ---------------- exponent shift and divider setup ----------------
  exp_ctl_t    ex_ctl;
  logic [30:0] ex_sum;
  logic [31:0] ex_e;

  assign ex_ctl = tm_ctl[TAYLOR_TERMS];
  assign ex_sum = ex_ctl.sum[32] ? 31'd0 : ex_ctl.sum[30:0];
  assign ex_e   = ex_ctl.zero ? 32'd0 : 32'(ex_sum >> ex_ctl.k);

  side_t       dv_side [0:DV_STEPS];
  logic [31:0] dv_rem  [0:DV_STEPS];
  logic [31:0] dv_d    [0:DV_STEPS];
  logic [30:0] dv_q    [0:DV_STEPS];
  logic        dv_vld  [0:DV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (adv) begin
      dv_vld[0] <= tm_vld[TAYLOR_TERMS];
    end
    if (adv) begin
      dv_side[0] <= ex_ctl.side;
      dv_d[0]    <= ONE_Q30 + ex_e;
      dv_rem[0]  <= (ex_ctl.side.sel == SEL_TANH) ? ONE_Q30 - ex_e : ONE_Q30;
      dv_q[0]    <= '0;
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  for (genvar j = 1; j <= DV_STEPS; j++) begin : g_div
    logic [32:0] cand;
    logic        ge;
    logic [30:0] q_next;

    assign cand = (j == 1) ? {1'b0, dv_rem[j-1]} : {dv_rem[j-1], 1'b0};
    assign ge   = cand >= {1'b0, dv_d[j-1]};

    // Insert this stage's quotient bit
    always_comb begin
      q_next              = dv_q[j-1];
      q_next[DV_STEPS-j]  = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[j] <= 1'b0;
      end else if (adv) begin
        dv_vld[j] <= dv_vld[j-1];
      end
      if (adv) begin
        dv_side[j]           <= dv_side[j-1];
        dv_d[j]              <= dv_d[j-1];
        dv_rem[j]            <= ge ? 32'(cand - {1'b0, dv_d[j-1]}) : cand[31:0];
        dv_q[j]              <= q_next;
      end
    end
  end

  // ---------------- derivative products ----------------
  side_t       pp_side;
  logic        pp_vld;
  logic [30:0] pp_val;
  logic [61:0] pp_prod;
  logic [30:0] q_fin;
  logic [30:0] q_other;

  assign q_fin   = dv_q[DV_STEPS];
  assign q_other = (dv_side[DV_STEPS].sel == SEL_SIGMOID) ? ONE_Q30[30:0] - q_fin : q_fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_vld <= 1'b0;
    end else if (adv) begin
      pp_vld <= dv_vld[DV_STEPS];
    end
    if (adv) begin
      pp_side <= dv_side[DV_STEPS];
      pp_val  <= (dv_side[DV_STEPS].sel == SEL_SIGMOID && dv_side[DV_STEPS].neg)
                 ? ONE_Q30[30:0] - q_fin : q_fin;
      pp_prod <= 62'(q_fin) * 62'(q_other);
    end
  end

  // ---------------- select, round and saturate ----------------
  logic [31:0]       rd_mag;
  logic              rd_neg;
  logic [31:0]       rd_sum;
  logic [31:0]       rd_r;
  logic [DATA_W-1:0] rd_word;
  logic              relu_pos;

  always_comb begin
    rd_mag   = {1'b0, pp_val};
    rd_neg   = 1'b0;
    relu_pos = !pp_side.neg && (pp_side.raw != '0);
    case (pp_side.sel)
      SEL_SIGMOID: begin
        if (pp_side.slope) rd_mag = 32'(pp_prod >> IBITS);
      end
      SEL_TANH: begin
        if (pp_side.slope) rd_mag = ONE_Q30 - 32'(pp_prod >> IBITS);
        else               rd_neg = pp_side.neg;
      end
      default: begin
        rd_mag = ONE_Q30;
      end
    endcase
    rd_sum = rd_mag + (32'd1 << (SH_IN - 1));
    rd_r   = rd_sum >> SH_IN;
    if (rd_neg) begin
      rd_word = (rd_r > 32'd32768) ? 16'h8000 : 16'(32'h10000 - rd_r);
    end else begin
      rd_word = (rd_r > 32'd32767) ? 16'h7FFF : rd_r[DATA_W-1:0];
    end
    case (pp_side.sel)
      SEL_SIGMOID, SEL_TANH: ;
      SEL_RELU: begin
        if (!relu_pos)          rd_word = '0;
        else if (!pp_side.slope) rd_word = pp_side.raw;
      end
      default: rd_word = '0;
    endcase
  end

  // Hold the output word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (adv) begin
      rsp.valid <= pp_vld;
    end
    if (adv) begin
      rsp.activation <= rd_word;
    end
  end

`ifndef ASSERT_OFF
  // Reduced argument stays below ln2 after the fix-up step
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (tm_vld[0] && !tm_ctl[0].zero) |-> (64'(tm_ctl[0].r) < LN2_Q30))
    else $error("range reduction remainder out of range");

  // Divider operands: e^-x never exceeds one
  a_exp_range: assert property (@(posedge clk) disable iff (rst)
    dv_vld[0] |-> (dv_d[0] <= (ONE_Q30 << 1)) && (dv_rem[0] <= dv_d[0]))
    else $error("exponential out of range");

  // Quotient never exceeds one
  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    dv_vld[DV_STEPS] |-> (32'(q_fin) <= ONE_Q30))
    else $error("divider quotient above one");

  // Sigmoid of a magnitude is at least one half
  a_sig_half: assert property (@(posedge clk) disable iff (rst)
    (dv_vld[DV_STEPS] && dv_side[DV_STEPS].sel == SEL_SIGMOID)
      |-> (32'(q_fin) >= (ONE_Q30 >> 1)))
    else $error("sigmoid below one half");
`endif

endmodule

`default_nettype wire

/* verif/afu_chk.sv */
// Scoreboard for the activation function unit: watches both channels,
// predicts each result word from the request word and compares in order.
// Depends on afu_pkg, afu_req_if and afu_rsp_if.
`default_nettype none

module afu_chk import afu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  afu_req_if        req,
  afu_rsp_if        rsp,
  output int        fails,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] ONE = 64'd1 << IBITS;
  localparam logic [63:0] LN2 = 64'd744261118;

  logic [15:0] act_q[$];

  // e^-a with a and result in Q.30
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] a);
    logic [63:0] k;
    logic [63:0] r;
    logic [63:0] term;
    logic signed [63:0] sum;
    k = a / LN2;
    r = a - k * LN2;
    term = ONE;
    sum = ONE;
    if (k >= 40) return 64'd0;
    for (int n = 1; n <= 14; n++) begin
      term = ((term * r) >> IBITS) / n;
      if (n & 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    return 64'(sum) >> k;
  endfunction

  // Round Q.30 magnitude to output format, apply sign, saturate
  function automatic logic [15:0] round_q30(input logic [63:0] mag, input logic neg);
    logic [63:0] r;
    r = (mag + (64'd1 << (IBITS - FRAC_BITS - 1))) >> (IBITS - FRAC_BITS);
    if (neg) begin
      if (r > 64'd32768) r = 64'd32768;
      return 16'(64'h10000 - r);
    end
    if (r > 64'd32767) r = 64'd32767;
    return r[15:0];
  endfunction

  function automatic logic [15:0] activation_of(input logic [1:0] sel, input logic slope,
                                                input logic [15:0] raw);
    logic neg;
    logic [63:0] mag;
    logic [63:0] a;
    logic [63:0] e;
    logic [63:0] s;
    logic [63:0] t;
    neg = raw[15];
    mag = neg ? 64'h10000 - raw : 64'(raw);
    a = mag << (IBITS - FRAC_BITS);
    case (sel)
      SEL_SIGMOID: begin
        e = exp_neg_q30(a);
        s = (ONE << IBITS) / (ONE + e);
        if (slope) return round_q30((s * (ONE - s)) >> IBITS, 1'b0);
        return round_q30(neg ? ONE - s : s, 1'b0);
      end
      SEL_RELU: begin
        if (neg || raw == 16'd0) return 16'd0;
        return slope ? round_q30(ONE, 1'b0) : raw;
      end
      SEL_TANH: begin
        e = exp_neg_q30(a << 1);
        t = ((ONE - e) << IBITS) / (ONE + e);
        if (slope) return round_q30(ONE - ((t * t) >> IBITS), 1'b0);
        return round_q30(t, neg);
      end
      default: return 16'd0;
    endcase
  endfunction

  assign pending = act_q.size();

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    if (rst) begin
      fails <= 0;
    end else begin
      if (req.valid && req.ready)
        act_q.insert(act_q.size(), activation_of(req.req_type, req.want_slope, req.sample));
      if (rsp.valid && rsp.ready) begin
        if (act_q.size() == 0) begin
          $error("activation: unexpected word %0d", $signed(rsp.activation));
          fails <= fails + 1;
        end else if (act_q[0] !== rsp.activation) begin
          $error("activation: expected %0d actual %0d",
                 $signed(act_q[0]), $signed(rsp.activation));
          fails <= fails + 1;
          void'(act_q.pop_front());
        end else begin
          void'(act_q.pop_front());
        end
      end
    end
  end
endmodule

`default_nettype wire

/* verif/tb.sv */
// Testbench top for the activation function unit: clock, reset, request
// stimulus, result back-pressure, watchdog and verdict.
// Depends on afu_pkg, the two channel interfaces, the block and afu_chk.
`default_nettype none

module tb import afu_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;
  logic quiet;
  logic hold_req;
  int   fails;
  int   pending;
  int   idle_cycles;

  afu_req_if req_ch();
  afu_rsp_if rsp_ch();

  activation_function_unit dut (.clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch));
  afu_chk chk (.clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
               .fails(fails), .pending(pending));

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Send one request word, optionally after an idle burst
  task automatic send_word(input logic [1:0] sel, input logic slope, input logic [15:0] x,
                           input bit gap);
    if (gap) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= sel;
    req_ch.want_slope <= slope;
    req_ch.sample     <= x;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Random sample: mostly the interesting range around zero, some full range, some extremes
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 4096)) - 2048);
      2: return 16'($signed($urandom_range(0, 40000)) - 20000);
      default: return 16'($urandom_range(0, 1) ? 16'h7fff - $urandom_range(0, 3)
                                                : 16'h8000 + $urandom_range(0, 3));
    endcase
  endfunction

  // Stimulus
  initial begin
    logic [15:0] edges [8];
    logic [1:0]  sel;
    edges = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h1000, 16'hf000, 16'h0800};
    rst = 1'b1;
    quiet = 1'b0;
    hold_req = 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= 2'd0;
    req_ch.want_slope <= 1'b0;
    req_ch.sample <= 16'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every selector and flag against the sample extremes
    for (int i = 0; i < 24; i++)
      send_word(2'(i % 3), 1'((i / 3) % 2), edges[i / 6 + (i % 2) * 4], 1'b0);
    send_word(2'd3, 1'b1, 16'h8000, 1'b0);
    send_word(2'd3, 1'b0, 16'h7fff, 1'b0);

    // Random part
    for (int n = 0; n < 1900; n++) begin
      if (n == 500) hold_req <= 1'b1;
      if (n == 1000) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if (n == 1600) quiet <= 1'b1;
      sel = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      send_word(sel, 1'($urandom), pick_sample(), !quiet && $urandom_range(0, 4) == 0);
    end
    req_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result back-pressure: random stalls, one long hold-off, none at the end
  initial begin
    logic held;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (200) @(posedge clk);
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles with no accepted word on either channel
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 5000) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end
endmodule

`default_nettype wire

/* sim.f */
src/afu_pkg.sv
src/afu_req_if.sv
src/afu_rsp_if.sv
src/activation_function_unit.sv
verif/afu_chk.sv
verif/tb.sv
